### rtl/core/mcdt_pkg.sv
// Shared types, constants and register map for the multi-channel down timer block.
package mcdt_pkg;

   localparam int NUM_TIMERS = 3;
   localparam int COUNT_BITS = 64;

   // Timers that have a tick lane and an interrupt line.
   localparam int TICK_LANES = 3;

   localparam int WORD_BITS     = 32;
   localparam int INDEX_BITS    = 5;
   localparam int WORD_SEL_BITS = 3;

   localparam int REQ_TDATA_BITS = 40;
   localparam int REQ_TUSER_BITS = 2;
   localparam int RSP_TDATA_BITS = 40;
   localparam int RSP_PAD_BITS   = RSP_TDATA_BITS - WORD_BITS - TICK_LANES;

   localparam int CTL_WIDE_BIT     = 16;
   localparam int CTL_RUN_BIT      = 1;
   localparam int CTL_PERIODIC_BIT = 0;
   localparam int INT_ENABLE_BIT   = 0;
   localparam int INT_RAW_BIT      = 1;
   localparam int INT_MASKED_BIT   = 2;
   localparam int INT_CLEAR_BIT    = 3;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [WORD_SEL_BITS-1:0] {
      W_LOAD_LO  = 3'd0,
      W_LOAD_HI  = 3'd1,
      W_VALUE_LO = 3'd2,
      W_VALUE_HI = 3'd3,
      W_CTL      = 3'd4,
      W_INT      = 3'd5,
      W_SHDW_LO  = 3'd6,
      W_SHDW_HI  = 3'd7
   } word_type;

   // Work handed to one timer channel for the transaction being retired.
   typedef struct packed {
      logic                 commit;
      op_type               op;
      word_type             word;
      logic [WORD_BITS-1:0] data;
      logic                 hit;
      logic                 tick;
   } chan_req_type;

endpackage

### rtl/core/mcdt_channel.sv
// One down-counting timer: its registers, tick and reload logic, and read mux.
module mcdt_channel (
   input  logic                          clock,
   input  logic                          reset,
   input  mcdt_pkg::chan_req_type        req,
   output logic [mcdt_pkg::WORD_BITS-1:0] read_data,
   output logic                          irq_next
);
   import mcdt_pkg::*;

   localparam logic [COUNT_BITS-1:0] FULL_MASK = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] LOW_MASK  = COUNT_BITS'(64'hFFFF_FFFF);

   logic [COUNT_BITS-1:0] reload_ff, reload_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  wide_ff, wide_in;
   logic                  running_ff, running_in;
   logic                  periodic_ff, periodic_in;
   logic                  enable_ff, enable_in;
   logic                  raw_ff, raw_in;

   logic [COUNT_BITS-1:0] cur_mask;
   logic [COUNT_BITS-1:0] new_mask;
   logic [COUNT_BITS-1:0] cur_count;
   logic [COUNT_BITS-1:0] dec_count;
   logic [63:0]           reload64;
   logic [63:0]           count64;
   logic [63:0]           hi_merge;
   logic [63:0]           lo_merge;

   assign cur_mask  = wide_ff ? FULL_MASK : LOW_MASK;
   assign new_mask  = req.data[CTL_WIDE_BIT] ? FULL_MASK : LOW_MASK;
   assign cur_count = count_ff & cur_mask;
   assign dec_count = cur_count - COUNT_BITS'(1);
   assign reload64  = 64'(reload_ff);
   assign count64   = 64'(cur_count);
   assign hi_merge  = {req.data, reload64[31:0]};
   assign lo_merge  = {reload64[63:32], req.data};

   always_comb begin
      reload_in   = reload_ff;
      count_in    = count_ff;
      wide_in     = wide_ff;
      running_in  = running_ff;
      periodic_in = periodic_ff;
      enable_in   = enable_ff;
      raw_in      = raw_ff;

      if (req.commit) begin
         if (req.op == OP_TICK && req.tick && running_ff) begin
            // A count already at zero expires at once; otherwise it expires on reaching zero.
            count_in = (cur_count == '0) ? '0 : dec_count;
            if (cur_count == '0 || dec_count == '0) begin
               raw_in = 1'b1;
               if (periodic_ff) begin
                  count_in = reload_ff & cur_mask;
               end else begin
                  running_in = 1'b0;
               end
            end
         end else if (req.op == OP_WRITE && req.hit) begin
            case (req.word)
               W_LOAD_LO: begin
                  reload_in = lo_merge[COUNT_BITS-1:0];
               end
               W_LOAD_HI: begin
                  reload_in = hi_merge[COUNT_BITS-1:0];
               end
               W_CTL: begin
                  wide_in     = req.data[CTL_WIDE_BIT];
                  periodic_in = req.data[CTL_PERIODIC_BIT];
                  running_in  = req.data[CTL_RUN_BIT];
                  if (req.data[CTL_RUN_BIT] && !running_ff) begin
                     count_in = reload_ff & new_mask;
                  end
               end
               W_INT: begin
                  enable_in = req.data[INT_ENABLE_BIT];
                  if (req.data[INT_CLEAR_BIT]) begin
                     raw_in = 1'b0;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign irq_next = raw_in & enable_in;

   always_comb begin
      read_data = '0;
      if (req.op == OP_READ && req.hit) begin
         case (req.word)
            W_LOAD_LO:              read_data = reload64[31:0];
            W_LOAD_HI:              read_data = reload64[63:32];
            W_VALUE_LO, W_SHDW_LO:  read_data = count64[31:0];
            W_VALUE_HI, W_SHDW_HI:  read_data = count64[63:32];
            W_CTL: begin
               read_data[CTL_WIDE_BIT]     = wide_ff;
               read_data[CTL_RUN_BIT]      = running_ff;
               read_data[CTL_PERIODIC_BIT] = periodic_ff;
            end
            W_INT: begin
               read_data[INT_ENABLE_BIT] = enable_ff;
               read_data[INT_RAW_BIT]    = raw_ff;
               read_data[INT_MASKED_BIT] = enable_ff & raw_ff;
            end
            default: read_data = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff   <= '0;
         count_ff    <= '0;
         wide_ff     <= 1'b0;
         running_ff  <= 1'b0;
         periodic_ff <= 1'b0;
         enable_ff   <= 1'b0;
         raw_ff      <= 1'b0;
      end else begin
         reload_ff   <= reload_in;
         count_ff    <= count_in;
         wide_ff     <= wide_in;
         running_ff  <= running_in;
         periodic_ff <= periodic_in;
         enable_ff   <= enable_in;
         raw_ff      <= raw_in;
      end
   end

endmodule

### rtl/core/multi_channel_down_timer_regs_top.sv
// Top level of the multi-channel down timer register block: input stage, timers, result stage.
//
//   channel | direction | tdata (low bit up)                           | tuser
//   req     | in        | word_index 5, write_data 32, tick_mask 3     | op 2
//   rsp     | out       | read_data 32, irq_lines 3, zero pad 5        | -
//
// Each transaction is registered at the input and retired into the result register, where
// the timer registers update; one transaction per cycle is sustained while rsp is not stalled.
// Reset empties both stages and clears every timer register to zero.
// A stalled rsp holds the input stage; req stays ready while the input stage is empty.
module multi_channel_down_timer_regs_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // word_index [4:0], write_data [36:5], tick_mask [39:37]
   input  logic [mcdt_pkg::REQ_TDATA_BITS-1:0]   req_tdata,
   // op [1:0]
   input  logic [mcdt_pkg::REQ_TUSER_BITS-1:0]   req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // read_data [31:0], irq_lines [34:32], zero [39:35]
   output logic [mcdt_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata
);
   import mcdt_pkg::*;

   logic                     s1_valid_ff, s1_valid_in;
   op_type                   s1_op_ff;
   logic [INDEX_BITS-1:0]    s1_idx_ff;
   logic [WORD_BITS-1:0]     s1_data_ff;
   logic [TICK_LANES-1:0]    s1_tick_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0]     rsp_read_ff;
   logic [TICK_LANES-1:0]    rsp_irq_ff;

   logic                     out_stall;
   logic                     advance;
   logic                     req_accept;

   logic [WORD_BITS-1:0]     chan_read [NUM_TIMERS];
   logic [NUM_TIMERS-1:0]    chan_irq;
   logic [WORD_BITS-1:0]     read_or;
   logic [TICK_LANES-1:0]    irq_lines;

   assign out_stall  = rsp_valid_ff & ~rsp_tready;
   assign advance    = s1_valid_ff & ~out_stall;
   assign req_tready = ~s1_valid_ff | ~out_stall;
   assign req_accept = req_tvalid & req_tready;

   assign s1_valid_in  = req_accept | (s1_valid_ff & out_stall);
   assign rsp_valid_in = advance | out_stall;

   for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_timer
      chan_req_type creq;
      logic         lane_tick;

      // Only timers below TICK_LANES have a tick lane.
      if (i < TICK_LANES) begin : g_lane
         assign lane_tick = s1_tick_ff[i];
      end else begin : g_no_lane
         assign lane_tick = 1'b0;
      end

      always_comb begin
         creq.commit = advance;
         creq.op     = s1_op_ff;
         creq.word   = word_type'(s1_idx_ff[WORD_SEL_BITS-1:0]);
         creq.data   = s1_data_ff;
         creq.hit    = (int'(s1_idx_ff[INDEX_BITS-1:WORD_SEL_BITS]) == i);
         creq.tick   = lane_tick;
      end

      mcdt_channel u_channel (
         .clock     (clock),
         .reset     (reset),
         .req       (creq),
         .read_data (chan_read[i]),
         .irq_next  (chan_irq[i])
      );
   end

   always_comb begin
      read_or = '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
         read_or = read_or | chan_read[i];
      end
   end

   always_comb begin
      irq_lines = '0;
      for (int i = 0; i < NUM_TIMERS && i < TICK_LANES; i++) begin
         irq_lines[i] = chan_irq[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff   <= op_type'(req_tuser[1:0]);
         s1_idx_ff  <= req_tdata[INDEX_BITS-1:0];
         s1_data_ff <= req_tdata[INDEX_BITS+WORD_BITS-1:INDEX_BITS];
         s1_tick_ff <= req_tdata[INDEX_BITS+WORD_BITS+TICK_LANES-1:INDEX_BITS+WORD_BITS];
      end
      if (advance) begin
         rsp_read_ff <= read_or;
         rsp_irq_ff  <= irq_lines;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_BITS{1'b0}}, rsp_irq_ff, rsp_read_ff};

`ifndef SYNTHESIS
   // A held input stage behind a stalled result must block new transactions.
   a_block_when_full: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_stall) |-> !req_tready)
      else $error("req accepted while input stage is held");

   // A retired transaction always shows up as a result on the next cycle.
   a_retire_to_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("retired transaction produced no result");

   // An accepted transaction is present in the input stage on the next cycle.
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted transaction was lost");
`endif

endmodule
